FILE: sv/serial_command_motor_drive_defines.svh
// assertion macros for the port-level checker
`ifndef SERIAL_COMMAND_MOTOR_DRIVE_DEFINES_SVH
`define SERIAL_COMMAND_MOTOR_DRIVE_DEFINES_SVH

// same-cycle implication, reset masks the check
`define SCMD_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SCMD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/scmd_pkg.sv
// shared types, constants and step tables for the serial command motor drive
package scmd_pkg;

  localparam int NumSteps = 5;
  localparam int StepW    = 3;

  typedef enum logic [2:0] {
    MODE_STOP,
    MODE_FWD,
    MODE_REV,
    MODE_LEFT,
    MODE_RIGHT
  } mode_t;

  // configuration register indexes
  localparam logic [2:0] CFG_PERIOD    = 3'd0;
  localparam logic [2:0] CFG_KICK_PCT  = 3'd1;
  localparam logic [2:0] CFG_KICK_MS   = 3'd2;
  localparam logic [2:0] CFG_STOP_CM   = 3'd3;
  localparam logic [2:0] CFG_BUZZER_MS = 3'd4;
  localparam logic [2:0] CFG_LOOP_MS   = 3'd5;

  // configuration reset values
  localparam logic [15:0] RstPeriod   = 16'd1874;
  localparam logic [6:0]  RstKickPct  = 7'd80;
  localparam logic [9:0]  RstStopCm   = 10'd3;
  localparam logic [15:0] RstBuzzerMs = 16'd2000;
  localparam logic [9:0]  RstLoopMs   = 10'd60;

  // command bytes
  localparam logic [7:0] CMD_FWD     = 8'h77;
  localparam logic [7:0] CMD_REV     = 8'h73;
  localparam logic [7:0] CMD_LEFT    = 8'h61;
  localparam logic [7:0] CMD_RIGHT   = 8'h64;
  localparam logic [7:0] CMD_STOP    = 8'h30;
  localparam logic [7:0] CMD_SPACE   = 8'h20;
  localparam logic [7:0] CMD_DOWN    = 8'h6B;
  localparam logic [7:0] CMD_DOWN_UC = 8'h4B;
  localparam logic [7:0] CMD_UP      = 8'h6C;
  localparam logic [7:0] CMD_UP_UC   = 8'h4C;
  localparam logic [7:0] CMD_BUZZ    = 8'h62;

  // direction pin patterns
  localparam logic [3:0] DIR_NONE  = 4'h0;
  localparam logic [3:0] DIR_FWD   = 4'h5;
  localparam logic [3:0] DIR_REV   = 4'hA;
  localparam logic [3:0] DIR_LEFT  = 4'h1;
  localparam logic [3:0] DIR_RIGHT = 4'h4;

  localparam logic [6:0]  PctFull   = 7'd100;
  localparam logic [15:0] EchoMaxUs = 16'd40000;
  localparam logic [15:0] UsPerCm   = 16'd58;

  // width / 58 as multiply by ceil(2^22 / 58), exact for widths up to 40000
  localparam logic [16:0] DistRecip = 17'd72316;
  localparam int          DistShift = 22;
  // x / 100 as multiply by ceil(2^30 / 100), exact for x below 2^23
  localparam logic [23:0] PctRecip  = 24'd10737419;
  localparam int          PctShift  = 30;

  typedef struct packed {
    logic [15:0] period;
    logic [6:0]  kick_pct;
    logic [9:0]  stop_cm;
    logic [15:0] buzzer_ms;
    logic [9:0]  loop_ms;
  } cfg_t;

  // one result on its way to the scaling stages
  typedef struct packed {
    logic [3:0]  dir;
    logic [6:0]  duty_a;
    logic [6:0]  duty_b;
    logic        kick;
    logic        buzz;
    logic        duty_rpt;
    logic [6:0]  user_pct;
    logic [6:0]  applied_pct;
    logic        dist_rpt;
    logic        dist_neg;
    logic [15:0] width;
    logic        last;
  } entry_t;

  function automatic logic [6:0] user_pct_f(input logic [StepW-1:0] idx);
    logic [6:0] v;
    case (idx)
      3'd0:    v = 7'd5;
      3'd1:    v = 7'd25;
      3'd2:    v = 7'd50;
      3'd3:    v = 7'd75;
      default: v = 7'd100;
    endcase
    return v;
  endfunction

  function automatic logic [6:0] apply_pct_f(input logic [StepW-1:0] idx);
    logic [6:0] v;
    case (idx)
      3'd0:    v = 7'd55;
      3'd1:    v = 7'd61;
      3'd2:    v = 7'd67;
      3'd3:    v = 7'd73;
      default: v = 7'd79;
    endcase
    return v;
  endfunction

endpackage

FILE: sv/scmd_cfg.sv
// configuration register file
module scmd_cfg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_idx,
  input  logic [15:0]         cfg_wdata,
  output scmd_pkg::cfg_t      cfg
);

  scmd_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.period    <= scmd_pkg::RstPeriod;
      cfg_r.kick_pct  <= scmd_pkg::RstKickPct;
      cfg_r.stop_cm   <= scmd_pkg::RstStopCm;
      cfg_r.buzzer_ms <= scmd_pkg::RstBuzzerMs;
      cfg_r.loop_ms   <= scmd_pkg::RstLoopMs;
    end else if (cfg_we) begin
      case (cfg_idx)
        scmd_pkg::CFG_PERIOD:    cfg_r.period    <= cfg_wdata;
        scmd_pkg::CFG_KICK_PCT:  cfg_r.kick_pct  <= cfg_wdata[6:0];
        // kick hold time only matters to whoever consumes kick_hold
        scmd_pkg::CFG_KICK_MS:   cfg_r           <= cfg_r;
        scmd_pkg::CFG_STOP_CM:   cfg_r.stop_cm   <= cfg_wdata[9:0];
        scmd_pkg::CFG_BUZZER_MS: cfg_r.buzzer_ms <= cfg_wdata;
        scmd_pkg::CFG_LOOP_MS:   cfg_r.loop_ms   <= cfg_wdata[9:0];
        default:                 cfg_r           <= cfg_r;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: sv/scmd_ctrl.sv
// input register, command decode and motion / buzzer / autostop state
module scmd_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  scmd_pkg::cfg_t     cfg,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_func,
  input  logic [7:0]         in_cmd_byte,
  input  logic [15:0]        in_echo_width_us,
  input  logic               in_echo_ok,
  output logic               ent_valid,
  input  logic               ent_ready,
  output scmd_pkg::entry_t   ent
);

  localparam logic [scmd_pkg::StepW-1:0] StepMax = scmd_pkg::StepW'(scmd_pkg::NumSteps - 1);
  localparam logic [scmd_pkg::StepW-1:0] StepRst = scmd_pkg::StepW'(1);
  localparam logic [scmd_pkg::StepW-1:0] StepOne = scmd_pkg::StepW'(1);

  // held input beat
  logic        vld_r;
  logic        func_r;
  logic [7:0]  byte_r;
  logic [15:0] width_r;
  logic        ok_r;
  logic        phase_r;

  // drive state
  scmd_pkg::mode_t             mode_r, mode_nxt;
  logic [scmd_pkg::StepW-1:0]  step_r, step_nxt;
  logic [6:0]                  last_a_r, last_a_nxt;
  logic [6:0]                  last_b_r, last_b_nxt;
  logic [3:0]                  dir_r, dir_nxt;
  logic [15:0]                 buz_left_r, buz_left_nxt;
  logic                        buz_lvl_r, buz_lvl_nxt;

  logic                        is_apply;
  scmd_pkg::mode_t             mode_sel;
  logic [scmd_pkg::StepW-1:0]  step_sel;
  logic [3:0]                  dir_sel;
  logic [6:0]                  user, applied, da, db, kick_clip;
  logic                        ka, kb;
  logic                        dist_neg, near;
  logic [16:0]                 near_lim;
  logic [1:0]                  n_ent;
  scmd_pkg::entry_t            e_kick, e_fin;
  logic                        last_ent, done, accept;

  always_comb begin
    is_apply     = 1'b0;
    mode_sel     = mode_r;
    step_sel     = step_r;
    buz_left_nxt = buz_left_r;
    buz_lvl_nxt  = buz_lvl_r;
    if (!func_r) begin
      case (byte_r)
        scmd_pkg::CMD_FWD: begin
          is_apply = 1'b1;
          mode_sel = scmd_pkg::MODE_FWD;
        end
        scmd_pkg::CMD_REV: begin
          is_apply = 1'b1;
          mode_sel = scmd_pkg::MODE_REV;
        end
        scmd_pkg::CMD_LEFT: begin
          is_apply = 1'b1;
          mode_sel = scmd_pkg::MODE_LEFT;
        end
        scmd_pkg::CMD_RIGHT: begin
          is_apply = 1'b1;
          mode_sel = scmd_pkg::MODE_RIGHT;
        end
        scmd_pkg::CMD_STOP, scmd_pkg::CMD_SPACE: begin
          is_apply = 1'b1;
          mode_sel = scmd_pkg::MODE_STOP;
        end
        scmd_pkg::CMD_DOWN, scmd_pkg::CMD_DOWN_UC: begin
          is_apply = 1'b1;
          if (step_r != '0) step_sel = step_r - StepOne;
        end
        scmd_pkg::CMD_UP, scmd_pkg::CMD_UP_UC: begin
          is_apply = 1'b1;
          if (step_r < StepMax) step_sel = step_r + StepOne;
        end
        scmd_pkg::CMD_BUZZ: buz_left_nxt = cfg.buzzer_ms;
        default: ;
      endcase
    end else begin
      if (buz_left_r != '0) begin
        buz_lvl_nxt  = 1'b1;
        buz_left_nxt = (buz_left_r >= 16'(cfg.loop_ms)) ? buz_left_r - 16'(cfg.loop_ms) : '0;
      end else begin
        buz_lvl_nxt = 1'b0;
      end
    end
  end

  always_comb begin
    user    = scmd_pkg::user_pct_f(step_sel);
    applied = scmd_pkg::apply_pct_f(step_sel);
    da      = '0;
    db      = '0;
    case (mode_sel)
      scmd_pkg::MODE_FWD: begin
        dir_sel = scmd_pkg::DIR_FWD;
        da      = applied;
        db      = applied;
      end
      scmd_pkg::MODE_REV: begin
        dir_sel = scmd_pkg::DIR_REV;
        da      = applied;
        db      = applied;
      end
      scmd_pkg::MODE_LEFT: begin
        dir_sel = scmd_pkg::DIR_LEFT;
        da      = applied;
      end
      scmd_pkg::MODE_RIGHT: begin
        dir_sel = scmd_pkg::DIR_RIGHT;
        db      = applied;
      end
      default: dir_sel = scmd_pkg::DIR_NONE;
    endcase
    kick_clip = (cfg.kick_pct > scmd_pkg::PctFull) ? scmd_pkg::PctFull : cfg.kick_pct;
    ka = (last_a_r == '0) && (da != '0) && (da < cfg.kick_pct);
    kb = (last_b_r == '0) && (db != '0) && (db < cfg.kick_pct);
  end

  // 0 < width/58 <= stop  <=>  58 <= width < 58*(stop+1)
  always_comb begin
    dist_neg = !ok_r || (width_r > scmd_pkg::EchoMaxUs);
    near_lim = 17'(cfg.stop_cm) * 17'(scmd_pkg::UsPerCm) + 17'(scmd_pkg::UsPerCm);
    near     = !dist_neg && (width_r >= scmd_pkg::UsPerCm) && ({1'b0, width_r} < near_lim);
  end

  always_comb begin
    mode_nxt   = mode_r;
    step_nxt   = step_r;
    last_a_nxt = last_a_r;
    last_b_nxt = last_b_r;
    dir_nxt    = dir_r;
    n_ent      = 2'd0;
    if (!func_r) begin
      if (is_apply) begin
        mode_nxt   = mode_sel;
        step_nxt   = step_sel;
        dir_nxt    = dir_sel;
        last_a_nxt = da;
        last_b_nxt = db;
        n_ent      = (ka || kb) ? 2'd2 : 2'd1;
      end
    end else begin
      n_ent = 2'd1;
      if (near) begin
        mode_nxt   = scmd_pkg::MODE_STOP;
        dir_nxt    = scmd_pkg::DIR_NONE;
        last_a_nxt = '0;
        last_b_nxt = '0;
      end
    end
  end

  always_comb begin
    e_kick        = '0;
    e_kick.dir    = dir_sel;
    e_kick.duty_a = ka ? kick_clip : last_a_r;
    e_kick.duty_b = kb ? kick_clip : last_b_r;
    e_kick.kick   = 1'b1;
    e_kick.buzz   = buz_lvl_r;

    e_fin        = '0;
    e_fin.dir    = dir_nxt;
    e_fin.duty_a = last_a_nxt;
    e_fin.duty_b = last_b_nxt;
    e_fin.buzz   = buz_lvl_nxt;
    e_fin.last   = 1'b1;
    if (!func_r) begin
      e_fin.duty_rpt    = 1'b1;
      e_fin.user_pct    = user;
      e_fin.applied_pct = (mode_sel == scmd_pkg::MODE_STOP) ? '0 : applied;
    end else begin
      e_fin.dist_rpt = 1'b1;
      e_fin.dist_neg = dist_neg;
      // zero width on timeout keeps the distance product within 32 bits
      e_fin.width    = dist_neg ? '0 : width_r;
    end
  end

  assign ent       = (n_ent == 2'd2 && !phase_r) ? e_kick : e_fin;
  assign ent_valid = vld_r && (n_ent != 2'd0);
  assign last_ent  = (n_ent != 2'd2) || phase_r;
  assign done      = vld_r && ((n_ent == 2'd0) || (ent_ready && last_ent));
  assign in_ready  = !vld_r || done;
  assign accept    = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r      <= 1'b0;
      phase_r    <= 1'b0;
      mode_r     <= scmd_pkg::MODE_STOP;
      step_r     <= StepRst;
      last_a_r   <= '0;
      last_b_r   <= '0;
      dir_r      <= scmd_pkg::DIR_NONE;
      buz_left_r <= '0;
      buz_lvl_r  <= 1'b0;
    end else begin
      if (accept) begin
        vld_r <= 1'b1;
      end else if (done) begin
        vld_r <= 1'b0;
      end
      if (done) begin
        phase_r    <= 1'b0;
        mode_r     <= mode_nxt;
        step_r     <= step_nxt;
        last_a_r   <= last_a_nxt;
        last_b_r   <= last_b_nxt;
        dir_r      <= dir_nxt;
        buz_left_r <= buz_left_nxt;
        buz_lvl_r  <= buz_lvl_nxt;
      end else if (ent_valid && ent_ready) begin
        // kick beat went out, final beat next
        phase_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      func_r  <= in_func;
      byte_r  <= in_cmd_byte;
      width_r <= in_echo_width_us;
      ok_r    <= in_echo_ok;
    end
  end

endmodule

FILE: sv/scmd_scale.sv
// pwm and distance scaling: product stage then reciprocal stage into the output register
module scmd_scale (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [15:0]        period,
  input  logic               ent_valid,
  output logic               ent_ready,
  input  scmd_pkg::entry_t   ent,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [3:0]         out_dir_pins,
  output logic [15:0]        out_pulse_a,
  output logic [15:0]        out_pulse_b,
  output logic               out_kick_hold,
  output logic               out_buzzer_on,
  output logic               out_duty_report,
  output logic [6:0]         out_user_pct,
  output logic [6:0]         out_applied_pct,
  output logic               out_dist_report,
  output logic signed [10:0] out_dist_cm,
  output logic               out_last_of_run
);

  logic              s2_vld_r;
  scmd_pkg::entry_t  s2_ent_r;
  logic [22:0]       prod_a_r, prod_b_r;
  logic [31:0]       dprod_r;

  logic              o_vld_r;
  logic [3:0]        o_dir_r;
  logic [15:0]       o_pa_r, o_pb_r;
  logic              o_kick_r, o_buzz_r, o_drep_r, o_dist_rpt_r, o_last_r;
  logic [6:0]        o_user_r, o_apct_r;
  logic [10:0]       o_dist_r;

  logic              out_take, s2_load;
  logic [46:0]       scl_a, scl_b;
  logic [10:0]       dist_nxt;

  assign out_take  = !o_vld_r || out_ready;
  assign ent_ready = !s2_vld_r || out_take;
  assign s2_load   = ent_valid && ent_ready;

  always_comb begin
    scl_a = 47'(prod_a_r) * 47'(scmd_pkg::PctRecip);
    scl_b = 47'(prod_b_r) * 47'(scmd_pkg::PctRecip);
    if (!s2_ent_r.dist_rpt) begin
      dist_nxt = '0;
    end else if (s2_ent_r.dist_neg) begin
      dist_nxt = '1;
    end else begin
      dist_nxt = 11'(dprod_r >> scmd_pkg::DistShift);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
      o_vld_r  <= 1'b0;
    end else begin
      if (ent_ready) s2_vld_r <= ent_valid;
      if (out_take)  o_vld_r  <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load) begin
      s2_ent_r <= ent;
      prod_a_r <= 23'(period) * 23'(ent.duty_a);
      prod_b_r <= 23'(period) * 23'(ent.duty_b);
      dprod_r  <= 32'(ent.width) * 32'(scmd_pkg::DistRecip);
    end
    if (out_take && s2_vld_r) begin
      o_dir_r      <= s2_ent_r.dir;
      o_pa_r       <= scl_a[scmd_pkg::PctShift +: 16];
      o_pb_r       <= scl_b[scmd_pkg::PctShift +: 16];
      o_kick_r     <= s2_ent_r.kick;
      o_buzz_r     <= s2_ent_r.buzz;
      o_drep_r     <= s2_ent_r.duty_rpt;
      o_user_r     <= s2_ent_r.user_pct;
      o_apct_r     <= s2_ent_r.applied_pct;
      o_dist_rpt_r <= s2_ent_r.dist_rpt;
      o_dist_r     <= dist_nxt;
      o_last_r     <= s2_ent_r.last;
    end
  end

  assign out_valid       = o_vld_r;
  assign out_dir_pins    = o_dir_r;
  assign out_pulse_a     = o_pa_r;
  assign out_pulse_b     = o_pb_r;
  assign out_kick_hold   = o_kick_r;
  assign out_buzzer_on   = o_buzz_r;
  assign out_duty_report = o_drep_r;
  assign out_user_pct    = o_user_r;
  assign out_applied_pct = o_apct_r;
  assign out_dist_report = o_dist_rpt_r;
  assign out_dist_cm     = $signed(o_dist_r);
  assign out_last_of_run = o_last_r;

endmodule

FILE: sv/serial_command_motor_drive.sv
// serial command motor drive: decode/state stage, pwm product stage, output register
// a result passes the input, product and output registers in that order
// throughput: one input beat per cycle when the output is not stalled; a beat that
// gives a kick result holds the decode stage until both of its result beats are taken
// a stalled result still lets one beat into each earlier stage before in_ready drops
// reset (sync, active low) stops both motors, sets step 1, clears buzzer, loads defaults
module serial_command_motor_drive (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_idx,
  input  logic [15:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_func,
  input  logic [7:0]         in_cmd_byte,
  input  logic [15:0]        in_echo_width_us,
  input  logic               in_echo_ok,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [3:0]         out_dir_pins,
  output logic [15:0]        out_pulse_a,
  output logic [15:0]        out_pulse_b,
  output logic               out_kick_hold,
  output logic               out_buzzer_on,
  output logic               out_duty_report,
  output logic [6:0]         out_user_pct,
  output logic [6:0]         out_applied_pct,
  output logic               out_dist_report,
  output logic signed [10:0] out_dist_cm,
  output logic               out_last_of_run
);

  scmd_pkg::cfg_t   cfg;
  scmd_pkg::entry_t ent;
  logic             ent_valid, ent_ready;

  scmd_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  scmd_ctrl u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_func          (in_func),
    .in_cmd_byte      (in_cmd_byte),
    .in_echo_width_us (in_echo_width_us),
    .in_echo_ok       (in_echo_ok),
    .ent_valid        (ent_valid),
    .ent_ready        (ent_ready),
    .ent              (ent)
  );

  scmd_scale u_scale (
    .clk             (clk),
    .rst_n           (rst_n),
    .period          (cfg.period),
    .ent_valid       (ent_valid),
    .ent_ready       (ent_ready),
    .ent             (ent),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_dir_pins    (out_dir_pins),
    .out_pulse_a     (out_pulse_a),
    .out_pulse_b     (out_pulse_b),
    .out_kick_hold   (out_kick_hold),
    .out_buzzer_on   (out_buzzer_on),
    .out_duty_report (out_duty_report),
    .out_user_pct    (out_user_pct),
    .out_applied_pct (out_applied_pct),
    .out_dist_report (out_dist_report),
    .out_dist_cm     (out_dist_cm),
    .out_last_of_run (out_last_of_run)
  );

endmodule

FILE: sv/scmd_chk.sv
// port-level checker for the serial command motor drive, bound to the top level
`include "serial_command_motor_drive_defines.svh"

module scmd_chk (
  input logic               clk,
  input logic               rst_n,
  input logic               cfg_we,
  input logic [2:0]         cfg_idx,
  input logic [15:0]        cfg_wdata,
  input logic               in_valid,
  input logic               in_ready,
  input logic               in_func,
  input logic [7:0]         in_cmd_byte,
  input logic [15:0]        in_echo_width_us,
  input logic               in_echo_ok,
  input logic               out_valid,
  input logic               out_ready,
  input logic [3:0]         out_dir_pins,
  input logic [15:0]        out_pulse_a,
  input logic [15:0]        out_pulse_b,
  input logic               out_kick_hold,
  input logic               out_buzzer_on,
  input logic               out_duty_report,
  input logic [6:0]         out_user_pct,
  input logic [6:0]         out_applied_pct,
  input logic               out_dist_report,
  input logic signed [10:0] out_dist_cm,
  input logic               out_last_of_run
);

  // stalled result beat holds
  `SCMD_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_pulse_a) && $stable(out_pulse_b) && $stable(out_dist_cm), "result beat changed while stalled")

  // a kick beat is never the last of its run and the final duty beat follows it directly
  `SCMD_ASSERT_NXT(a_kick_then_final, out_valid && out_ready && out_kick_hold, out_valid && out_duty_report && out_last_of_run, "kick beat not followed by duty report")

  // a distance report is a single-beat run with no duty fields
  `SCMD_ASSERT(a_dist_alone, out_valid && out_dist_report, out_last_of_run && !out_duty_report && !out_kick_hold, "distance beat mixed with duty fields")

  // zero applied duty in a report means both motors are stopped
  `SCMD_ASSERT(a_stop_quiet, out_valid && out_duty_report && out_applied_pct == 7'd0, out_dir_pins == 4'h0 && out_pulse_a == 16'd0 && out_pulse_b == 16'd0, "stop report with motor drive active")

endmodule

bind serial_command_motor_drive scmd_chk u_scmd_chk (.*);

FILE: bench/scmd_checker.sv
// checker for the serial command motor drive: predicts each result beat and compares it
`timescale 1ns / 1ps
module scmd_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_idx,
  input  logic [15:0]        cfg_wdata,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic               in_func,
  input  logic [7:0]         in_cmd_byte,
  input  logic [15:0]        in_echo_width_us,
  input  logic               in_echo_ok,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [3:0]         out_dir_pins,
  input  logic [15:0]        out_pulse_a,
  input  logic [15:0]        out_pulse_b,
  input  logic               out_kick_hold,
  input  logic               out_buzzer_on,
  input  logic               out_duty_report,
  input  logic [6:0]         out_user_pct,
  input  logic [6:0]         out_applied_pct,
  input  logic               out_dist_report,
  input  logic signed [10:0] out_dist_cm,
  input  logic               out_last_of_run,
  output int                 fail_count,
  output int                 pending
);

  typedef struct packed {
    logic [3:0]  dir;
    logic [15:0] pulse_a;
    logic [15:0] pulse_b;
    logic        kick;
    logic        buzz;
    logic        duty_rpt;
    logic [6:0]  user_pct;
    logic [6:0]  applied_pct;
    logic        dist_rpt;
    logic [10:0] dist_cm;
    logic        last;
  } drive_beat_t;

  drive_beat_t expected_beats[$];
  int beats_seen;

  // register mirror
  logic [15:0] period;
  logic [6:0]  kick_pct;
  logic [9:0]  stop_cm;
  logic [15:0] buzz_ms;
  logic [9:0]  loop_ms;

  // drive state mirror
  scmd_pkg::mode_t mode;
  logic [2:0]  step;
  logic [6:0]  duty_a;
  logic [6:0]  duty_b;
  logic [3:0]  dir;
  logic [15:0] buzz_left;
  logic        buzz_lvl;

  function automatic logic [15:0] pwm_counts(input logic [6:0] duty);
    logic [31:0] lim;
    logic [31:0] counts;
    lim = (duty > 7'd100) ? 32'd100 : {25'd0, duty};
    counts = ({16'd0, period} * lim) / 32'd100;
    return counts[15:0];
  endfunction

  function automatic logic [6:0] user_step_pct(input logic [2:0] idx);
    case (idx)
      3'd0:    return 7'd5;
      3'd1:    return 7'd25;
      3'd2:    return 7'd50;
      3'd3:    return 7'd75;
      default: return 7'd100;
    endcase
  endfunction

  function automatic logic [6:0] drive_step_pct(input logic [2:0] idx);
    case (idx)
      3'd0:    return 7'd55;
      3'd1:    return 7'd61;
      3'd2:    return 7'd67;
      3'd3:    return 7'd73;
      default: return 7'd79;
    endcase
  endfunction

  task automatic flag_mismatch(input string msg);
    $display("mismatch at result beat %0d: %s", beats_seen, msg);
    fail_count++;
  endtask

  task automatic push_beat(input logic [6:0] da, input logic [6:0] db, input logic kick,
                           input logic drep, input logic [6:0] upct, input logic [6:0] apct,
                           input logic drp, input logic [10:0] dcm, input logic last);
    drive_beat_t b;
    b.dir         = dir;
    b.pulse_a     = pwm_counts(da);
    b.pulse_b     = pwm_counts(db);
    b.kick        = kick;
    b.buzz        = buzz_lvl;
    b.duty_rpt    = drep;
    b.user_pct    = upct;
    b.applied_pct = apct;
    b.dist_rpt    = drp;
    b.dist_cm     = dcm;
    b.last        = last;
    expected_beats.push_back(b);
  endtask

  // set pins and duties for the current motion, with a kick beat first if needed
  task automatic drive_motors();
    logic [6:0] upct;
    logic [6:0] apct;
    logic [6:0] da;
    logic [6:0] db;
    logic       ka;
    logic       kb;
    upct = user_step_pct(step);
    apct = drive_step_pct(step);
    da = 7'd0;
    db = 7'd0;
    case (mode)
      scmd_pkg::MODE_FWD: begin
        dir = scmd_pkg::DIR_FWD;
        da = apct;
        db = apct;
      end
      scmd_pkg::MODE_REV: begin
        dir = scmd_pkg::DIR_REV;
        da = apct;
        db = apct;
      end
      scmd_pkg::MODE_LEFT: begin
        dir = scmd_pkg::DIR_LEFT;
        da = apct;
      end
      scmd_pkg::MODE_RIGHT: begin
        dir = scmd_pkg::DIR_RIGHT;
        db = apct;
      end
      default: dir = scmd_pkg::DIR_NONE;
    endcase
    if (mode == scmd_pkg::MODE_STOP) begin
      duty_a = 7'd0;
      duty_b = 7'd0;
      push_beat(7'd0, 7'd0, 1'b0, 1'b1, upct, 7'd0, 1'b0, 11'd0, 1'b1);
    end else begin
      ka = (duty_a == 7'd0) && (da != 7'd0) && (da < kick_pct);
      kb = (duty_b == 7'd0) && (db != 7'd0) && (db < kick_pct);
      if (ka || kb) begin
        push_beat(ka ? kick_pct : duty_a, kb ? kick_pct : duty_b, 1'b1, 1'b0, 7'd0, 7'd0,
                  1'b0, 11'd0, 1'b0);
      end
      duty_a = da;
      duty_b = db;
      push_beat(da, db, 1'b0, 1'b1, upct, apct, 1'b0, 11'd0, 1'b1);
    end
  endtask

  task automatic predict_input(input logic f, input logic [7:0] c, input logic [15:0] w,
                               input logic ok);
    int cm;
    if (!f) begin
      case (c)
        scmd_pkg::CMD_FWD: begin
          mode = scmd_pkg::MODE_FWD;
          drive_motors();
        end
        scmd_pkg::CMD_REV: begin
          mode = scmd_pkg::MODE_REV;
          drive_motors();
        end
        scmd_pkg::CMD_LEFT: begin
          mode = scmd_pkg::MODE_LEFT;
          drive_motors();
        end
        scmd_pkg::CMD_RIGHT: begin
          mode = scmd_pkg::MODE_RIGHT;
          drive_motors();
        end
        scmd_pkg::CMD_STOP, scmd_pkg::CMD_SPACE: begin
          mode = scmd_pkg::MODE_STOP;
          drive_motors();
        end
        scmd_pkg::CMD_DOWN, scmd_pkg::CMD_DOWN_UC: begin
          if (step != 3'd0) step = step - 3'd1;
          drive_motors();
        end
        scmd_pkg::CMD_UP, scmd_pkg::CMD_UP_UC: begin
          if (step < scmd_pkg::NumSteps - 1) step = step + 3'd1;
          drive_motors();
        end
        scmd_pkg::CMD_BUZZ: buzz_left = buzz_ms;
        default: ;
      endcase
    end else begin
      if (buzz_left != 16'd0) begin
        buzz_lvl = 1'b1;
        buzz_left = (buzz_left >= 16'(loop_ms)) ? buzz_left - 16'(loop_ms) : 16'd0;
      end else begin
        buzz_lvl = 1'b0;
      end
      cm = (!ok || w > scmd_pkg::EchoMaxUs) ? -1 : int'(w / scmd_pkg::UsPerCm);
      // close object forces a stop
      if (cm > 0 && cm <= int'(stop_cm)) begin
        mode = scmd_pkg::MODE_STOP;
        dir = scmd_pkg::DIR_NONE;
        duty_a = 7'd0;
        duty_b = 7'd0;
      end
      push_beat(duty_a, duty_b, 1'b0, 1'b0, 7'd0, 7'd0, 1'b1, cm[10:0], 1'b1);
    end
  endtask

  task automatic check_beat();
    drive_beat_t e;
    if (expected_beats.size() == 0) begin
      flag_mismatch("result beat with nothing expected");
    end else begin
      e = expected_beats.pop_front();
      if (out_dir_pins !== e.dir)
        flag_mismatch($sformatf("dir_pins got %h exp %h", out_dir_pins, e.dir));
      if (out_pulse_a !== e.pulse_a)
        flag_mismatch($sformatf("pulse_a got %0d exp %0d", out_pulse_a, e.pulse_a));
      if (out_pulse_b !== e.pulse_b)
        flag_mismatch($sformatf("pulse_b got %0d exp %0d", out_pulse_b, e.pulse_b));
      if (out_kick_hold !== e.kick)
        flag_mismatch($sformatf("kick_hold got %b exp %b", out_kick_hold, e.kick));
      if (out_buzzer_on !== e.buzz)
        flag_mismatch($sformatf("buzzer_on got %b exp %b", out_buzzer_on, e.buzz));
      if (out_duty_report !== e.duty_rpt)
        flag_mismatch($sformatf("duty_report got %b exp %b", out_duty_report, e.duty_rpt));
      if (out_user_pct !== e.user_pct)
        flag_mismatch($sformatf("user_pct got %0d exp %0d", out_user_pct, e.user_pct));
      if (out_applied_pct !== e.applied_pct)
        flag_mismatch($sformatf("applied_pct got %0d exp %0d", out_applied_pct,
                                e.applied_pct));
      if (out_dist_report !== e.dist_rpt)
        flag_mismatch($sformatf("dist_report got %b exp %b", out_dist_report, e.dist_rpt));
      if (out_dist_cm !== e.dist_cm)
        flag_mismatch($sformatf("dist_cm got %0d exp %0d", out_dist_cm, $signed(e.dist_cm)));
      if (out_last_of_run !== e.last)
        flag_mismatch($sformatf("last_of_run got %b exp %b", out_last_of_run, e.last));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      period = scmd_pkg::RstPeriod;
      kick_pct = scmd_pkg::RstKickPct;
      stop_cm = scmd_pkg::RstStopCm;
      buzz_ms = scmd_pkg::RstBuzzerMs;
      loop_ms = scmd_pkg::RstLoopMs;
      mode = scmd_pkg::MODE_STOP;
      step = 3'd1;
      duty_a = 7'd0;
      duty_b = 7'd0;
      dir = scmd_pkg::DIR_NONE;
      buzz_left = 16'd0;
      buzz_lvl = 1'b0;
      expected_beats.delete();
      fail_count = 0;
      beats_seen = 0;
    end else begin
      // output beats first: a beat accepted this edge cannot answer an input of this edge
      if (out_valid && out_ready) begin
        check_beat();
        beats_seen++;
      end
      if (cfg_we) begin
        case (cfg_idx)
          scmd_pkg::CFG_PERIOD:    period = cfg_wdata;
          scmd_pkg::CFG_KICK_PCT:  kick_pct = cfg_wdata[6:0];
          scmd_pkg::CFG_STOP_CM:   stop_cm = cfg_wdata[9:0];
          scmd_pkg::CFG_BUZZER_MS: buzz_ms = cfg_wdata;
          scmd_pkg::CFG_LOOP_MS:   loop_ms = cfg_wdata[9:0];
          default: ;  // kick hold time only matters downstream
        endcase
      end
      if (in_valid && in_ready)
        predict_input(in_func, in_cmd_byte, in_echo_width_us, in_echo_ok);
    end
    pending = expected_beats.size();
  end

endmodule

FILE: bench/testbench.sv
// top of the serial command motor drive bench: clock, reset, stimulus and verdict
`timescale 1ns / 1ps
module testbench;

  localparam int RunLimit   = 400000;
  localparam int PhaseItems = 150;
  localparam int NumPhases  = 8;

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic [2:0]         cfg_idx;
  logic [15:0]        cfg_wdata;
  logic               in_valid;
  logic               in_ready;
  logic               in_func;
  logic [7:0]         in_cmd_byte;
  logic [15:0]        in_echo_width_us;
  logic               in_echo_ok;
  logic               out_valid;
  logic               out_ready;
  logic [3:0]         out_dir_pins;
  logic [15:0]        out_pulse_a;
  logic [15:0]        out_pulse_b;
  logic               out_kick_hold;
  logic               out_buzzer_on;
  logic               out_duty_report;
  logic [6:0]         out_user_pct;
  logic [6:0]         out_applied_pct;
  logic               out_dist_report;
  logic signed [10:0] out_dist_cm;
  logic               out_last_of_run;

  int         fail_count;
  int         pending;
  int         send_idle_pct;
  int         stall_pct;
  int         cycles = 0;
  logic [9:0] stop_cm_now;

  serial_command_motor_drive u_top (.*);

  scmd_checker u_drive_check (.*);

  initial clk = 1'b0;
  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= RunLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("status: fail");
      $finish;
    end
  end

  always @(negedge clk) out_ready <= ($urandom_range(99) >= stall_pct);

  // valid stays up from one beat to the next unless the sender idles
  task automatic send_item(input logic f, input logic [7:0] c, input logic [15:0] w,
                           input logic ok);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_func <= f;
    in_cmd_byte <= c;
    in_echo_width_us <= w;
    in_echo_ok <= ok;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_cmd(input logic [7:0] c);
    send_item(1'b0, c, 16'($urandom_range(65535)), 1'($urandom_range(1)));
  endtask

  task automatic send_echo(input logic [15:0] w, input logic ok);
    send_item(1'b1, 8'($urandom_range(255)), w, ok);
  endtask

  // hold off until every expected beat is back, plus slack for beats with no result
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic load_config(input logic [15:0] period, input logic [6:0] kick_pct,
                             input logic [7:0] kick_ms, input logic [9:0] stop_cm,
                             input logic [15:0] buzz_ms, input logic [9:0] loop_ms);
    drain();
    write_reg(scmd_pkg::CFG_PERIOD, period);
    write_reg(scmd_pkg::CFG_KICK_PCT, {9'd0, kick_pct});
    write_reg(scmd_pkg::CFG_KICK_MS, {8'd0, kick_ms});
    write_reg(scmd_pkg::CFG_STOP_CM, {6'd0, stop_cm});
    write_reg(scmd_pkg::CFG_BUZZER_MS, buzz_ms);
    write_reg(scmd_pkg::CFG_LOOP_MS, {6'd0, loop_ms});
    stop_cm_now = stop_cm;
  endtask

  function automatic logic [7:0] pick_motion();
    case ($urandom_range(5))
      0:       return scmd_pkg::CMD_FWD;
      1:       return scmd_pkg::CMD_REV;
      2:       return scmd_pkg::CMD_LEFT;
      3:       return scmd_pkg::CMD_RIGHT;
      4:       return scmd_pkg::CMD_STOP;
      default: return scmd_pkg::CMD_SPACE;
    endcase
  endfunction

  function automatic logic [7:0] pick_step();
    case ($urandom_range(3))
      0:       return scmd_pkg::CMD_DOWN;
      1:       return scmd_pkg::CMD_DOWN_UC;
      2:       return scmd_pkg::CMD_UP;
      default: return scmd_pkg::CMD_UP_UC;
    endcase
  endfunction

  // echo widths: many near the stop distance so autostop fires both ways
  function automatic logic [15:0] echo_width();
    int          r;
    int          cm;
    logic [31:0] w;
    r = $urandom_range(99);
    if (r < 40) begin
      cm = $urandom_range(stop_cm_now + 2);
      w = cm * scmd_pkg::UsPerCm + $urandom_range(57);
    end else if (r < 80) begin
      w = $urandom_range(scmd_pkg::EchoMaxUs);
    end else if (r < 90) begin
      w = $urandom_range(65535);
    end else begin
      case ($urandom_range(3))
        0:       w = 0;
        1:       w = scmd_pkg::EchoMaxUs;
        2:       w = scmd_pkg::EchoMaxUs + 1;
        default: w = 16'hFFFF;
      endcase
    end
    return w[15:0];
  endfunction

  initial begin
    int         r;
    int         made;
    bit         paused;
    logic [7:0] noise;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = scmd_pkg::CFG_PERIOD;
    cfg_wdata = 16'd0;
    in_valid = 1'b0;
    in_func = 1'b0;
    in_cmd_byte = 8'd0;
    in_echo_width_us = 16'd0;
    in_echo_ok = 1'b0;
    out_ready = 1'b0;
    send_idle_pct = 0;
    stall_pct = 0;
    stop_cm_now = scmd_pkg::RstStopCm;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: kicks, step limits, stops, buzzer and echo corners at reset settings
    send_cmd(scmd_pkg::CMD_FWD);
    send_cmd(scmd_pkg::CMD_UP);
    send_cmd(scmd_pkg::CMD_UP);
    send_cmd(scmd_pkg::CMD_UP_UC);
    send_cmd(scmd_pkg::CMD_UP_UC);
    send_cmd(scmd_pkg::CMD_REV);
    send_cmd(scmd_pkg::CMD_DOWN_UC);
    send_cmd(scmd_pkg::CMD_STOP);
    send_cmd(scmd_pkg::CMD_LEFT);
    send_cmd(scmd_pkg::CMD_RIGHT);
    send_cmd(scmd_pkg::CMD_SPACE);
    send_cmd(scmd_pkg::CMD_DOWN);
    send_cmd(scmd_pkg::CMD_DOWN);
    send_cmd(scmd_pkg::CMD_DOWN);
    send_cmd(scmd_pkg::CMD_DOWN);
    send_cmd(scmd_pkg::CMD_FWD);
    send_cmd(scmd_pkg::CMD_BUZZ);
    send_echo(scmd_pkg::EchoMaxUs, 1'b1);
    send_echo(16'd174, 1'b1);
    send_echo(16'd0, 1'b1);
    send_echo(scmd_pkg::EchoMaxUs + 16'd1, 1'b1);
    send_echo(16'hFFFF, 1'b1);
    send_echo(16'd1000, 1'b0);
    send_cmd(8'hFF);
    send_cmd(8'h00);

    for (int ph = 0; ph < NumPhases; ph++) begin
      case (ph)
        0: ;
        1: load_config(16'hFFFF, 7'd100, 8'd255, 10'd689, 16'hFFFF, 10'd1);
        2: load_config(16'd1, 7'd0, 8'd1, 10'd0, 16'd0, 10'd1023);
        3: load_config(scmd_pkg::RstPeriod, scmd_pkg::RstKickPct, 8'd30, scmd_pkg::RstStopCm,
                       scmd_pkg::RstBuzzerMs, scmd_pkg::RstLoopMs);
        default: load_config(16'($urandom_range(65535, 1)), 7'($urandom_range(100)),
                             8'($urandom_range(255, 1)), 10'($urandom_range(689)),
                             16'($urandom_range(65535)), 10'($urandom_range(1023, 1)));
      endcase
      case (ph % 4)
        0: begin
          send_idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          send_idle_pct = 83;
          stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct = 83;
        end
        default: begin
          send_idle_pct = 21;
          stall_pct = 21;
        end
      endcase
      made = 0;
      paused = 1'b0;
      while (made < PhaseItems) begin
        r = $urandom_range(99);
        if (r < 35) begin
          send_cmd(pick_motion());
          made++;
        end else if (r < 55) begin
          send_cmd(pick_step());
          made++;
        end else if (r < 59) begin
          send_cmd(scmd_pkg::CMD_BUZZ);
          made++;
        end else if (r < 90) begin
          send_echo(echo_width(), $urandom_range(9) != 0);
          made++;
        end else begin
          // noise byte, mostly ignored
          noise = 8'($urandom_range(255));
          send_cmd(noise);
        end
        if (!paused && made >= PhaseItems / 2) begin
          drain();
          paused = 1'b1;
        end
      end
    end

    drain();
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
